// ===== rtl/core/mtfkt_pkg.sv =====
// Shared types and codes for the move-to-front key table.
`timescale 1ns / 1ps

package mtfkt_pkg;

   localparam int KEY_W = 32;
   localparam int VAL_W = 32;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_SEARCH = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic signed [VAL_W-1:0] value;
   } entry_type;

endpackage

// ===== rtl/core/mtfkt_if.sv =====
// Command and response channel interfaces of the move-to-front key table.
`timescale 1ns / 1ps

interface mtfkt_req_if import mtfkt_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              cmd;
   logic signed [KEY_W-1:0] key;
   logic signed [VAL_W-1:0] value_in;

   modport source (output valid, output cmd, output key, output value_in, input ready);
   modport sink   (input valid, input cmd, input key, input value_in, output ready);
endinterface

interface mtfkt_rsp_if import mtfkt_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              status;
   logic signed [VAL_W-1:0] value_out;

   modport source (output valid, output status, output value_out, input ready);
   modport sink   (input valid, input status, input value_out, output ready);
endinterface

// ===== rtl/core/move_to_front_key_table_top.sv =====
// Top level of the move-to-front key table: command sequencer and response register.
//
// Usage: commands arrive as transactions on req_if (cmd, key, value_in) and each
// yields exactly one transaction on rsp_if (status, value_out). The table is an
// ordered list of up to CAPACITY key/value pairs in a single-port-write,
// single-port-read memory; one key comparator and the memory's write and read ports
// do all the work under a small sequencer.
// Work per command, with n entries stored:
//   insert: ripple the list back, one write per entry
//   search hit at position p: scan up to p, then ripple 0..p
//   delete hit at position p: scan up to p, then close the gap
//   miss: scan all n entries; full insert or unused code: straight to done.
// The memory ports move one entry per cycle in the scan, ripple and shift states. One
// command is in work at a time; req_if.ready is high only while the sequencer is idle.
// The response sits in an output register: the next command is accepted while
// it waits, and a finished command holds until rsp_if.ready frees the register.
// Reset (synchronous, active high) empties the table and drops any response;
// entries are not cleared, since only positions below the fill count are read.
`timescale 1ns / 1ps

module move_to_front_key_table_top import mtfkt_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   mtfkt_req_if.sink   req_if,
   mtfkt_rsp_if.source rsp_if
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_RIPPLE,
      S_SHIFT,
      S_DONE
   } state_type;

   state_type               state_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        idx_ff;
   logic [CNT_W-1:0]        limit_ff;
   logic [1:0]              cmd_ff;
   logic signed [KEY_W-1:0] key_ff;
   entry_type               hold_ff;
   status_type              res_status_ff;
   logic signed [VAL_W-1:0] res_value_ff;
   logic                    rsp_valid_ff;
   logic [1:0]              rsp_status_ff;
   logic signed [VAL_W-1:0] rsp_value_ff;

   logic                    mem_we;
   logic [IDX_W-1:0]        mem_waddr;
   entry_type               mem_wdata;
   logic [IDX_W-1:0]        mem_raddr;
   entry_type               mem_rdata;

   logic [CNT_W-1:0]        idx_plus1;
   logic [CNT_W-1:0]        idx_plus2;
   logic                    key_hit;

   assign idx_plus1 = idx_ff + CNT_W'(1);
   assign idx_plus2 = idx_ff + CNT_W'(2);

   // shared key comparator on the entry just read
   assign key_hit = (mem_rdata.key == key_ff);

   mtfkt_store #(
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // drive memory port from sequencer state
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_ff[IDX_W-1:0];
      mem_wdata = mem_rdata;
      mem_raddr = idx_ff[IDX_W-1:0];
      unique case (state_ff)
         S_IDLE: begin
            mem_raddr = '0;
         end
         S_SCAN: begin
            mem_raddr = idx_plus1[IDX_W-1:0];
         end
         S_RIPPLE: begin
            // write carried entry, read the one it displaces
            mem_we    = 1'b1;
            mem_wdata = (idx_ff == '0) ? hold_ff : mem_rdata;
         end
         S_SHIFT: begin
            // move next entry forward, prefetch the one after it
            mem_we    = 1'b1;
            mem_raddr = idx_plus2[IDX_W-1:0];
         end
         default: begin
         end
      endcase
   end

   // sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop a taken response unless a new one loads on this edge
         if (rsp_valid_ff && rsp_if.ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_if.valid) begin
                  cmd_ff        <= req_if.cmd;
                  key_ff        <= req_if.key;
                  hold_ff       <= '{key: req_if.key, value: req_if.value_in};
                  idx_ff        <= '0;
                  limit_ff      <= count_ff;
                  res_status_ff <= ST_DONE;
                  res_value_ff  <= '0;
                  unique case (req_if.cmd)
                     CMD_INSERT: begin
                        if (count_ff == CNT_W'(CAPACITY)) begin
                           res_status_ff <= ST_FULL;
                           state_ff      <= S_DONE;
                        end else begin
                           state_ff <= S_RIPPLE;
                        end
                     end
                     CMD_DELETE, CMD_SEARCH: begin
                        if (count_ff == '0) begin
                           res_status_ff <= ST_MISS;
                           state_ff      <= S_DONE;
                        end else begin
                           state_ff <= S_SCAN;
                        end
                     end
                     default: begin
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_SCAN: begin
               if (key_hit) begin
                  if (cmd_ff == CMD_SEARCH) begin
                     hold_ff      <= mem_rdata;
                     res_value_ff <= mem_rdata.value;
                     limit_ff     <= idx_ff;
                     idx_ff       <= '0;
                     state_ff     <= S_RIPPLE;
                  end else if (idx_plus1 == count_ff) begin
                     count_ff <= count_ff - CNT_W'(1);
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_SHIFT;
                  end
               end else if (idx_plus1 == count_ff) begin
                  res_status_ff <= ST_MISS;
                  state_ff      <= S_DONE;
               end else begin
                  idx_ff <= idx_plus1;
               end
            end
            S_RIPPLE: begin
               if (idx_ff == limit_ff) begin
                  if (cmd_ff == CMD_INSERT) begin
                     count_ff <= count_ff + CNT_W'(1);
                  end
                  state_ff <= S_DONE;
               end else begin
                  idx_ff <= idx_plus1;
               end
            end
            S_SHIFT: begin
               if (idx_plus2 == count_ff) begin
                  count_ff <= count_ff - CNT_W'(1);
                  state_ff <= S_DONE;
               end else begin
                  idx_ff <= idx_plus1;
               end
            end
            S_DONE: begin
               // hold until the response register is free
               if (!rsp_valid_ff || rsp_if.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_value_ff  <= res_value_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_if.ready     = (state_ff == S_IDLE);
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.status    = rsp_status_ff;
   assign rsp_if.value_out = rsp_value_ff;

endmodule

// ===== rtl/core/mtfkt_store.sv =====
// Entry memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module mtfkt_store import mtfkt_pkg::*; #(
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  entry_type         wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output entry_type         rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // write and read; a read of the address being written returns the old entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== bench/mtf_table_checker.sv =====
// Checker for the move-to-front key table: predicts each response and compares it.
`timescale 1ns / 1ps

module mtf_table_checker import mtfkt_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [1:0]              req_cmd,
   input  logic signed [KEY_W-1:0] req_key,
   input  logic signed [VAL_W-1:0] req_value_in,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic [1:0]              rsp_status,
   input  logic signed [VAL_W-1:0] rsp_value_out,
   output int                      error_count,
   output int                      outstanding,
   output int                      full_drops,
   output int                      search_hits
);

   typedef struct {
      status_type              status;
      logic signed [VAL_W-1:0] value;
   } rsp_expect_type;

   // Shadow copy of the ordered list, front at index 0
   entry_type      list_entries [CAPACITY];
   int             list_fill;
   rsp_expect_type expected_rsp_q [$];
   int             failures;
   int             drops_seen;
   int             hits_seen;

   // Apply one command to the shadow list and return the response it should give
   function automatic rsp_expect_type predict_command(logic [1:0] cmd,
                                                      logic signed [KEY_W-1:0] key,
                                                      logic signed [VAL_W-1:0] value);
      rsp_expect_type res;
      entry_type      hit;
      int             pos;
      res.status = ST_DONE;
      res.value  = '0;
      pos = 0;
      while (pos < list_fill && list_entries[pos].key != key) pos++;
      case (cmd)
         CMD_INSERT: begin
            if (list_fill >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               for (int j = list_fill; j > 0; j--) list_entries[j] = list_entries[j-1];
               list_entries[0].key   = key;
               list_entries[0].value = value;
               list_fill++;
            end
         end
         CMD_DELETE: begin
            if (pos >= list_fill) begin
               res.status = ST_MISS;
            end else begin
               // close the gap behind the removed entry
               for (int j = pos; j + 1 < list_fill; j++) list_entries[j] = list_entries[j+1];
               list_fill--;
            end
         end
         CMD_SEARCH: begin
            if (pos >= list_fill) begin
               res.status = ST_MISS;
            end else begin
               hit       = list_entries[pos];
               res.value = hit.value;
               for (int j = pos; j > 0; j--) list_entries[j] = list_entries[j-1];
               list_entries[0] = hit;
            end
         end
         default: begin
            // unused code: no operation, plain done
         end
      endcase
      return res;
   endfunction

   // Count a failure; report only the first few
   task automatic flag_failure(string msg);
      failures++;
      if (failures <= 10) $display("checker: %0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin : watch_channels
      rsp_expect_type want;
      if (reset) begin
         expected_rsp_q.delete();
         list_fill  = 0;
         failures   = 0;
         drops_seen = 0;
         hits_seen  = 0;
      end else begin
         // retire the oldest expectation first: a response never belongs to
         // the command accepted on the same edge
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               flag_failure($sformatf("response with none pending: status %0d value %h",
                                      rsp_status, rsp_value_out));
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_status !== want.status)
                  flag_failure($sformatf("status: expected %0d, got %0d",
                                         want.status, rsp_status));
               if (rsp_value_out !== want.value)
                  flag_failure($sformatf("value_out: expected %h, got %h",
                                         want.value, rsp_value_out));
            end
         end
         if (req_valid && req_ready) begin
            want = predict_command(req_cmd, req_key, req_value_in);
            if (want.status == ST_FULL) drops_seen++;
            if (req_cmd == CMD_SEARCH && want.status == ST_DONE) hits_seen++;
            expected_rsp_q.push_back(want);
         end
      end
      error_count <= failures;
      outstanding <= expected_rsp_q.size();
      full_drops  <= drops_seen;
      search_hits <= hits_seen;
   end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the move-to-front key table: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb;
   import mtfkt_pkg::*;

   localparam int          CAPACITY        = 16;
   localparam int          RANDOM_ITEMS    = 1350;
   localparam int          IDLE_LIMIT      = 4000;
   localparam int          HOLD_OFF_CYCLES = 500;
   localparam int          DRAIN_CYCLES    = 40;
   localparam logic [1:0]  CMD_UNUSED      = 2'd3;
   localparam logic [31:0] KEY_MIN         = 32'h8000_0000;
   localparam logic [31:0] KEY_MAX         = 32'h7FFF_FFFF;
   localparam logic [31:0] ALL_ONES        = 32'hFFFF_FFFF;

   logic clock;
   logic reset;

   mtfkt_req_if req_if ();
   mtfkt_rsp_if rsp_if ();

   int error_count;
   int outstanding;
   int full_drops;
   int search_hits;
   int commands_accepted;
   int idle_cycles;
   int sent_count [4];
   logic [31:0] key_pool [12];

   move_to_front_key_table_top #(.CAPACITY(CAPACITY)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   mtf_table_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_ready     (req_if.ready),
      .req_cmd       (req_if.cmd),
      .req_key       (req_if.key),
      .req_value_in  (req_if.value_in),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_status    (rsp_if.status),
      .rsp_value_out (rsp_if.value_out),
      .error_count   (error_count),
      .outstanding   (outstanding),
      .full_drops    (full_drops),
      .search_hits   (search_hits)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Count accepted commands and end the run if the channels go quiet too long
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles       <= 0;
         commands_accepted <= 0;
      end else begin
         if (req_if.valid && req_if.ready) commands_accepted <= commands_accepted + 1;
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: no transaction for %0d cycles", IDLE_LIMIT);
            $display("tb: done, errors");
            $finish;
         end
      end
   end

   // Offer one command and hold it until the table accepts it
   task automatic send_command(input logic [1:0] cmd, input logic [31:0] key,
                               input logic [31:0] value);
      req_if.valid    <= 1'b1;
      req_if.cmd      <= cmd;
      req_if.key      <= key;
      req_if.value_in <= value;
      sent_count[cmd]++;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Drop valid and wait until every response has come back
   task automatic wait_for_drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Draw one command: mostly pooled keys so that hits and duplicates occur
   task automatic send_random_command(input int insert_pct, input int delete_pct);
      int          pick;
      logic [1:0]  cmd;
      logic [31:0] key;
      logic [31:0] value;
      pick = $urandom_range(0, 99);
      if (pick < 3)                               cmd = CMD_UNUSED;
      else if (pick < 3 + insert_pct)              cmd = CMD_INSERT;
      else if (pick < 3 + insert_pct + delete_pct) cmd = CMD_DELETE;
      else                                         cmd = CMD_SEARCH;
      key = ($urandom_range(0, 99) < 75) ? key_pool[$urandom_range(0, 11)] : $urandom;
      case ($urandom_range(0, 19))
         0:       value = KEY_MIN;
         1:       value = KEY_MAX;
         2:       value = '0;
         3:       value = ALL_ONES;
         default: value = $urandom;
      endcase
      send_command(cmd, key, value);
   endtask

   // Receiver: stall patterns in segments, plus one long hold-off
   initial begin
      int  seg_left;
      int  stall_pct;
      bit  held_off;
      rsp_if.ready <= 1'b0;
      seg_left  = 0;
      stall_pct = 0;
      held_off  = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && commands_accepted >= 300) begin
            held_off = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         if (seg_left == 0) begin
            seg_left = $urandom_range(10, 80);
            case ($urandom_range(0, 3))
               0:       stall_pct = 0;
               1:       stall_pct = 25;
               2:       stall_pct = 50;
               default: stall_pct = 85;
            endcase
         end
         rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
         seg_left--;
         @(posedge clock);
      end
   end

   // Stimulus
   initial begin
      int random_sent;
      int phase_left;
      int insert_pct;
      int delete_pct;
      int burst_left;
      bit first_phase;
      bit paused;

      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.cmd      <= CMD_INSERT;
      req_if.key      <= '0;
      req_if.value_in <= '0;
      for (int i = 0; i < 4; i++) sent_count[i] = 0;
      key_pool[0] = KEY_MIN;
      key_pool[1] = KEY_MAX;
      key_pool[2] = '0;
      key_pool[3] = ALL_ONES;
      for (int i = 4; i < 12; i++) key_pool[i] = $urandom;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty-table misses, extremes, hits, duplicates, unused code
      send_command(CMD_UNUSED, KEY_MAX, ALL_ONES);
      send_command(CMD_SEARCH, KEY_MAX, KEY_MIN);
      send_command(CMD_DELETE, '0, KEY_MAX);
      send_command(CMD_INSERT, KEY_MIN, KEY_MAX);
      send_command(CMD_INSERT, KEY_MAX, KEY_MIN);
      send_command(CMD_INSERT, '0, ALL_ONES);
      send_command(CMD_INSERT, ALL_ONES, '0);
      send_command(CMD_SEARCH, ALL_ONES, '0);
      send_command(CMD_SEARCH, KEY_MIN, ALL_ONES);
      send_command(CMD_INSERT, KEY_MAX, 32'h1234_5678);
      send_command(CMD_SEARCH, KEY_MAX, '0);
      send_command(CMD_DELETE, KEY_MAX, '0);
      send_command(CMD_SEARCH, KEY_MAX, '0);
      send_command(CMD_SEARCH, 32'd5, '0);
      send_command(CMD_DELETE, 32'd5, '0);
      send_command(CMD_UNUSED, KEY_MIN, KEY_MAX);
      send_command(CMD_DELETE, '0, '0);
      send_command(CMD_DELETE, ALL_ONES, '0);
      send_command(CMD_DELETE, KEY_MIN, '0);
      send_command(CMD_DELETE, KEY_MAX, '0);
      send_command(CMD_DELETE, KEY_MAX, '0);
      wait_for_drain();

      // Random: phases that fill, drain or churn the table, sent in bursts
      random_sent = 0;
      phase_left  = 0;
      insert_pct  = 0;
      delete_pct  = 0;
      burst_left  = $urandom_range(1, 16);
      first_phase = 1'b1;
      paused      = 1'b0;
      while (random_sent < RANDOM_ITEMS) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(20, 60);
            if (first_phase) begin
               insert_pct = 90;
               delete_pct = 2;
               first_phase = 1'b0;
            end else begin
               case ($urandom_range(0, 2))
                  0: begin insert_pct = 75; delete_pct = 10; end
                  1: begin insert_pct = 15; delete_pct = 55; end
                  default: begin insert_pct = 35; delete_pct = 25; end
               endcase
            end
         end
         send_random_command(insert_pct, delete_pct);
         random_sent++;
         phase_left--;
         if (!paused && random_sent >= RANDOM_ITEMS / 2) begin
            paused = 1'b1;
            wait_for_drain();
         end else begin
            burst_left--;
            if (burst_left == 0) begin
               req_if.valid <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
               burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                        : $urandom_range(1, 16);
            end
         end
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d commands: %0d insert, %0d delete, %0d search, %0d unused code",
               sent_count[0] + sent_count[1] + sent_count[2] + sent_count[3],
               sent_count[CMD_INSERT], sent_count[CMD_DELETE], sent_count[CMD_SEARCH],
               sent_count[CMD_UNUSED]);
      $display("tb: %0d search hits, %0d inserts dropped on a full table, one %0d-cycle stall",
               search_hits, full_drops, HOLD_OFF_CYCLES);
      if (error_count == 0 && outstanding == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

// ===== move_to_front_key_table_top.f =====
rtl/core/mtfkt_pkg.sv
rtl/core/mtfkt_if.sv
rtl/core/mtfkt_store.sv
rtl/core/move_to_front_key_table_top.sv
bench/mtf_table_checker.sv
bench/tb.sv
